@@ hdl/cbpa_pkg.sv @@
`default_nettype none
package cbpa_pkg;

  localparam int unsigned OffW   = 20;
  localparam int unsigned CountW = 9;
  localparam int unsigned BbW    = 13;
  localparam int unsigned EbW    = BbW + 1;  // rounded block size reaches 8192
  localparam int unsigned CntW   = 32;
  localparam logic [OffW-1:0] OffsetMax = 20'hFFFFF;
  localparam logic [CountW-1:0] RunMax = 9'd511;

  typedef enum logic [1:0] {
    StOk      = 2'd0,
    StNoSpace = 2'd1,
    StBadFree = 2'd2
  } status_e;

  localparam logic CmdAlloc = 1'b0;
  localparam logic CmdFree  = 1'b1;

  // Classified request passed from front to back
  typedef struct packed {
    logic              is_free;
    logic [OffW-1:0]   quot;     // need (alloc) or block index (free)
    logic              rem_nz;   // nonzero remainder
    logic [OffW-1:0]   foff;
    logic [EbW-1:0]    bb;       // effective block size
    logic [CountW:0]   usable;   // usable blocks, up to 511
  } req_t;

endpackage
`default_nettype wire

@@ hdl/contiguous_block_pool_allocator_core.sv @@
`default_nettype none
// First-fit block pool allocator. A free is either rejected or returns the blocks of
// its allocation; an allocate is rejected outright, fails after scanning the usable
// blocks if no run fits, or scans up to the first fitting run and marks it.
// Throughput: the front takes the next request once the last is queued; the back serves
// one at a time; the receiver cannot stall. Reset: all blocks free, counter zero, 64/256.
module contiguous_block_pool_allocator_core
  import cbpa_pkg::*;
#(
  parameter int unsigned NUM_BLOCKS = 256
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic              cmd_i,
  input  wire logic [OffW-1:0]   num_bytes_i,
  input  wire logic [OffW-1:0]   free_offset_i,
  input  wire logic              cfg_valid_i,
  output logic                   cfg_ready_o,
  input  wire logic              cfg_index_i,
  input  wire logic [BbW-1:0]    cfg_data_i,
  output logic                   result_valid_o,
  output logic [1:0]             status_o,
  output logic [OffW-1:0]        offset_o,
  output logic [CountW-1:0]      block_count_o,
  output logic [CntW-1:0]        coalesced_total_o
);

  logic [BbW-1:0]    block_bytes_q;
  logic [CountW-1:0] pool_blocks_q;
  logic              fq_valid, fq_ready, q_valid_q, bk_ready;
  req_t              fq_req, q_req_q;
  logic [CountW:0]   nb;

  assign cfg_ready_o = 1'b1;
  // pool_blocks never exceeds 511, so a larger pool limit changes nothing
  assign nb = (NUM_BLOCKS > 511) ? (CountW+1)'(511) : (CountW+1)'(NUM_BLOCKS);

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_bytes_q <= BbW'(64);
      pool_blocks_q <= CountW'(256);
    end else if (cfg_valid_i) begin
      if (cfg_index_i == 1'b0) block_bytes_q <= cfg_data_i;
      else pool_blocks_q <= cfg_data_i[CountW-1:0];
    end
  end

  cbpa_front u_front (
    .clk_i, .rst_ni, .start, .busy,
    .cmd_i, .num_bytes_i, .free_offset_i,
    .block_bytes_i (block_bytes_q),
    .pool_blocks_i (pool_blocks_q),
    .blk_limit_i   (nb),
    .req_valid_o   (fq_valid),
    .req_o         (fq_req),
    .req_ready_i   (fq_ready)
  );

  // One-entry queue between front and back
  assign fq_ready = !q_valid_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_valid_q <= 1'b0;
      q_req_q   <= '0;
    end else if (fq_valid && fq_ready) begin
      q_valid_q <= 1'b1;
      q_req_q   <= fq_req;
    end else if (bk_ready) begin
      q_valid_q <= 1'b0;
    end
  end

  cbpa_back #(.NumBlocks(NUM_BLOCKS)) u_back (
    .clk_i, .rst_ni,
    .req_valid_i       (q_valid_q),
    .req_i             (q_req_q),
    .req_ready_o       (bk_ready),
    .res_valid_o       (result_valid_o),
    .status_o, .offset_o, .block_count_o, .coalesced_total_o
  );

endmodule
`default_nettype wire

@@ hdl/cbpa_front.sv @@
`default_nettype none
// Front: accept a request, divide by the block size one bit per cycle (for an allocate,
// then divide OffsetMax as well), hand the classified request to the queue.
module cbpa_front
  import cbpa_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic              cmd_i,
  input  wire logic [OffW-1:0]   num_bytes_i,
  input  wire logic [OffW-1:0]   free_offset_i,
  input  wire logic [BbW-1:0]    block_bytes_i,
  input  wire logic [CountW-1:0] pool_blocks_i,
  input  wire logic [CountW:0]   blk_limit_i,
  output logic                   req_valid_o,
  output req_t                   req_o,
  input  wire logic              req_ready_i
);

  typedef enum logic [1:0] {FIdle, FDiv, FLim, FOut} fstate_e;

  fstate_e          state_q;
  logic [OffW-1:0]  dividend_q, quot_q, rem_q, need_quot_q;
  logic [4:0]       bit_q;
  logic             cmd_q, rem_nz_q, lim_pass_q;
  logic [OffW-1:0]  foff_q;
  logic [EbW-1:0]   bb_q;
  logic [CountW:0]  usable_q;

  logic [EbW-1:0]   bb_eff;
  logic [OffW:0]    rem_sh;
  logic [OffW:0]    rem_sub;
  logic [CountW:0]  n_clip;
  logic [OffW:0]    lim;

  assign busy = (state_q != FIdle);

  // Clamp and round the block size to a multiple of eight
  always_comb begin
    bb_eff = ({1'b0, block_bytes_i} + EbW'(7)) & ~EbW'(7);
    if (block_bytes_i < BbW'(8)) bb_eff = EbW'(8);
  end

  assign rem_sh  = {rem_q, dividend_q[OffW-1]};
  assign rem_sub = rem_sh - {{(OffW+1-EbW){1'b0}}, bb_q};

  // Clamp pool size to [1, min(NUM_BLOCKS, 511)]
  always_comb begin
    n_clip = {1'b0, pool_blocks_i};
    if (pool_blocks_i == '0) n_clip = (CountW+1)'(1);
    if (n_clip > blk_limit_i) n_clip = blk_limit_i;
  end

  // Blocks whose offset fits in the offset field
  assign lim = {1'b0, quot_q} + (OffW+1)'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= FIdle;
      dividend_q  <= '0;
      quot_q      <= '0;
      rem_q       <= '0;
      need_quot_q <= '0;
      bit_q       <= '0;
      cmd_q       <= CmdAlloc;
      rem_nz_q    <= 1'b0;
      lim_pass_q  <= 1'b0;
      foff_q      <= '0;
      bb_q        <= EbW'(8);
      usable_q    <= '0;
    end else begin
      unique case (state_q)
        FIdle: if (start) begin
          cmd_q      <= cmd_i;
          foff_q     <= free_offset_i;
          bb_q       <= bb_eff;
          usable_q   <= n_clip;
          dividend_q <= (cmd_i == CmdFree) ? free_offset_i : num_bytes_i;
          rem_q      <= '0;
          quot_q     <= '0;
          bit_q      <= '0;
          lim_pass_q <= 1'b0;
          state_q    <= FDiv;
        end
        // restoring division, one quotient bit per cycle
        FDiv: begin
          if (!rem_sub[OffW]) begin
            rem_q  <= rem_sub[OffW-1:0];
            quot_q <= {quot_q[OffW-2:0], 1'b1};
          end else begin
            rem_q  <= rem_sh[OffW-1:0];
            quot_q <= {quot_q[OffW-2:0], 1'b0};
          end
          bit_q <= bit_q + 5'd1;
          if (bit_q == 5'(OffW-1)) begin
            if (cmd_q == CmdAlloc && !lim_pass_q) begin
              // now divide OffsetMax to limit the usable blocks
              dividend_q <= OffsetMax;
              state_q    <= FLim;
            end else begin
              state_q <= FOut;
            end
          end else begin
            dividend_q <= dividend_q << 1;
          end
        end
        // latch the alloc quotient, then run the second division
        FLim: begin
          need_quot_q <= quot_q;
          rem_nz_q    <= (rem_q != '0);
          rem_q       <= '0;
          quot_q      <= '0;
          bit_q       <= '0;
          lim_pass_q  <= 1'b1;
          state_q     <= FDiv;
        end
        FOut: if (req_ready_i) state_q <= FIdle;
        default: state_q <= FIdle;
      endcase
    end
  end

  // Build the classified request
  always_comb begin
    req_o        = '0;
    req_o.bb     = bb_q;
    req_o.foff   = foff_q;
    req_o.usable = usable_q;
    if (cmd_q == CmdAlloc) begin
      req_o.is_free = 1'b0;
      req_o.quot    = need_quot_q;
      req_o.rem_nz  = rem_nz_q;
      if (lim < {{(OffW-CountW){1'b0}}, usable_q}) req_o.usable = lim[CountW:0];
    end else begin
      req_o.is_free = 1'b1;
      req_o.quot    = quot_q;
      req_o.rem_nz  = (rem_q != '0);
    end
  end

  assign req_valid_o = (state_q == FOut);

endmodule
`default_nettype wire

@@ hdl/cbpa_back.sv @@
`default_nettype none
// Back: for an allocate, scan the free map one block per cycle, then mark the run; for a free, release its blocks.
module cbpa_back
  import cbpa_pkg::*;
#(
  parameter int unsigned NumBlocks = 256
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              req_valid_i,
  input  req_t                   req_i,
  output logic                   req_ready_o,
  output logic                   res_valid_o,
  output logic [1:0]             status_o,
  output logic [OffW-1:0]        offset_o,
  output logic [CountW-1:0]      block_count_o,
  output logic [CntW-1:0]        coalesced_total_o
);

  localparam int unsigned IdxW = (NumBlocks > 1) ? $clog2(NumBlocks) : 1;

  typedef enum logic [2:0] {BIdle, BScan, BMark, BFreeRd, BFree, BDone} bstate_e;

  bstate_e            state_q;
  req_t               r_q;
  logic [NumBlocks-1:0] free_q, start_q;
  logic [CountW-1:0]  run_len_mem [NumBlocks];
  logic [CountW-1:0]  len_rd_q;
  logic [IdxW:0]      i_q, start_idx_q;
  logic [OffW:0]      need_q;
  logic [CountW:0]    run_q;
  logic [CountW-1:0]  left_q;
  logic [CntW-1:0]    ccount_q;
  logic               multi_q;
  logic [IdxW+EbW:0]  prod;

  assign req_ready_o       = (state_q == BIdle);
  assign coalesced_total_o = ccount_q;
  assign prod = start_idx_q * r_q.bb;

  always_ff @(posedge clk_i) begin
    if (state_q == BMark && left_q == CountW'(need_q))
      run_len_mem[start_idx_q[IdxW-1:0]] <= need_q[CountW-1:0];
    if (state_q == BFreeRd) len_rd_q <= run_len_mem[start_idx_q[IdxW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= BIdle;
      free_q        <= '1;
      start_q       <= '0;
      ccount_q      <= '0;
      res_valid_o   <= 1'b0;
      r_q           <= '0;
      i_q           <= '0;
      start_idx_q   <= '0;
      need_q        <= '0;
      run_q         <= '0;
      left_q        <= '0;
      multi_q       <= 1'b0;
      status_o      <= StOk;
      offset_o      <= '0;
      block_count_o <= '0;
    end else begin
      res_valid_o <= 1'b0;
      unique case (state_q)
        BIdle: if (req_valid_i) begin
          logic [OffW:0] nd;
          r_q <= req_i;
          i_q <= '0;
          run_q <= '0;
          if (!req_i.is_free) begin
            nd = {1'b0, req_i.quot} + (OffW+1)'(req_i.rem_nz);
            multi_q <= (nd > (OffW+1)'(1));
            if (nd == '0) nd = (OffW+1)'(1);
            need_q  <= nd;
            if (nd > (OffW+1)'(RunMax) || nd > (OffW+1)'(req_i.usable)) begin
              status_o <= StNoSpace; offset_o <= '0; block_count_o <= '0;
              res_valid_o <= 1'b1;
            end else begin
              state_q <= BScan;
            end
          end else begin
            if (req_i.rem_nz || req_i.quot >= OffW'(NumBlocks)
                || !start_q[req_i.quot[IdxW-1:0]]) begin
              status_o <= StBadFree; offset_o <= '0; block_count_o <= '0;
              res_valid_o <= 1'b1;
            end else begin
              start_idx_q <= req_i.quot[IdxW:0];
              state_q <= BFreeRd;
            end
          end
        end
        // first-fit run search, one block per cycle
        BScan: begin
          if ((CountW+1)'(i_q) >= r_q.usable) begin
            status_o <= StNoSpace; offset_o <= '0; block_count_o <= '0;
            res_valid_o <= 1'b1;
            state_q <= BIdle;
          end else if (free_q[i_q[IdxW-1:0]]) begin
            if (run_q == '0) start_idx_q <= i_q;
            run_q <= run_q + 1'b1;
            if ((OffW+1)'(run_q) + (OffW+1)'(1) == need_q) begin
              left_q  <= need_q[CountW-1:0];
              state_q <= BMark;
            end
            i_q <= i_q + 1'b1;
          end else begin
            run_q <= '0;
            i_q   <= i_q + 1'b1;
          end
        end
        // clear free bits over the run, one per cycle
        BMark: begin
          free_q[start_idx_q[IdxW-1:0] + IdxW'(need_q[CountW-1:0] - left_q)] <= 1'b0;
          left_q <= left_q - 1'b1;
          if (left_q == CountW'(1)) begin
            start_q[start_idx_q[IdxW-1:0]] <= 1'b1;
            if (multi_q) ccount_q <= ccount_q + 1'b1;
            state_q <= BDone;
          end
        end
        BFreeRd: begin
          i_q     <= start_idx_q;
          state_q <= BFree;
          left_q  <= '0;
        end
        // return blocks of the allocation, one per cycle
        BFree: begin
          if (left_q == len_rd_q || i_q >= (IdxW+1)'(NumBlocks)) begin
            start_q[start_idx_q[IdxW-1:0]] <= 1'b0;
            status_o <= StOk; offset_o <= r_q.foff; block_count_o <= len_rd_q;
            res_valid_o <= 1'b1;
            state_q <= BIdle;
          end else begin
            free_q[i_q[IdxW-1:0]] <= 1'b1;
            i_q    <= i_q + 1'b1;
            left_q <= left_q + 1'b1;
          end
        end
        BDone: begin
          status_o <= StOk;
          offset_o <= OffW'(prod);
          block_count_o <= need_q[CountW-1:0];
          res_valid_o <= 1'b1;
          state_q <= BIdle;
        end
        default: state_q <= BIdle;
      endcase
    end
  end

endmodule
`default_nettype wire
